/* design/md5_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Item types, round tables and round helper functions shared by the engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } out_item_t;

  typedef struct packed {
    logic       done;
    logic [3:0] widx;
  } mix_stat_t;

  typedef logic [3:0][31:0] chain_t;

  localparam chain_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS  = 6'd55;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] w;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    w = r;
      2'd1:    w = 4'(5 * r + 1);
      2'd2:    w = 4'(3 * r + 5);
      default: w = 4'(7 * r);
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

/* design/md5_digest_engine.sv */
// ----------------------------------------------------------------------------
// MD5 digest engine
// Hashes a byte stream and returns the 128-bit digest on the last item.
// ----------------------------------------------------------------------------
// Channel   Ports                          Carries
// input     in_valid  in_stall  in_data    one message byte and/or end mark
// result    out_valid out_stall out_data   digest as two 64-bit halves
//
// A byte that does not complete a block is written to the block buffer and the engine stays idle.
// A byte that completes a block sends the block through the shared round unit.
// For a last item, padding writes one byte a cycle,
// then one or two blocks go through the round unit.
// Reset is synchronous, loads the initial chaining words and clears the byte count.
// A digest waits in the output register; only the next digest waits for it.
// ----------------------------------------------------------------------------
module md5_digest_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  md5_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output md5_pkg::out_item_t out_data
);
  import md5_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MIX  = 5'b00010,
    S_PAD  = 5'b00100,
    S_LEN  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    RET_IDLE = 3'b001,
    RET_PAD  = 3'b010,
    RET_FIN  = 3'b100
  } ret_t;

  state_t      state_r, state_nxt;
  ret_t        ret_r, ret_nxt;
  logic        mix_start_r;
  logic [60:0] count_r;
  logic [5:0]  pad_pos_r;
  logic        pad_first_r;
  chain_t      chain_r;
  logic [31:0] blk_r [16];
  out_item_t   out_data_r;
  logic        out_valid_r;
  mix_stat_t   mix_stat;
  chain_t      mix_sum;
  logic        accept;
  logic        out_free;
  logic        byte_we;
  logic [5:0]  byte_pos;
  logic [7:0]  byte_val;
  logic [63:0] bit_len;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign bit_len  = {count_r, 3'b000};

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.has_byte && count_r[5:0] == LAST_POS) begin
            state_nxt = S_MIX;
            ret_nxt   = in_data.last ? RET_PAD : RET_IDLE;
          end else if (in_data.last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_MIX: begin
        if (mix_stat.done) begin
          unique case (ret_r)
            RET_IDLE: state_nxt = S_IDLE;
            RET_PAD:  state_nxt = S_PAD;
            RET_FIN:  state_nxt = S_FIN;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_PAD: begin
        if (pad_pos_r == LAST_POS) begin
          state_nxt = S_MIX;
          ret_nxt   = RET_PAD;
        end else if (pad_pos_r == LEN_POS) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        state_nxt = S_MIX;
        ret_nxt   = RET_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    byte_we  = 1'b0;
    byte_pos = count_r[5:0];
    byte_val = in_data.data_byte;
    if (accept && in_data.has_byte) begin
      byte_we = 1'b1;
    end else if (state_r == S_PAD) begin
      byte_we  = 1'b1;
      byte_pos = pad_pos_r;
      byte_val = pad_first_r ? PAD_BYTE : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_IDLE;
      mix_start_r <= 1'b0;
      count_r     <= '0;
      pad_pos_r   <= '0;
      pad_first_r <= 1'b0;
      chain_r     <= CHAIN_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      mix_start_r <= (state_nxt == S_MIX) && (state_r != S_MIX);
      if (accept) begin
        pad_first_r <= in_data.last;
        if (in_data.has_byte) begin
          count_r   <= count_r + 61'd1;
          pad_pos_r <= count_r[5:0] + 6'd1;
        end else begin
          pad_pos_r <= count_r[5:0];
        end
      end
      if (state_r == S_PAD) begin
        pad_pos_r   <= pad_pos_r + 6'd1;
        pad_first_r <= 1'b0;
      end
      if (state_r == S_MIX && mix_stat.done) begin
        chain_r <= mix_sum;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_FIN && out_free) begin
        chain_r <= CHAIN_INIT;
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      blk_r[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8] <= byte_val;
    end
    if (state_r == S_LEN) begin
      blk_r[14] <= bit_len[31:0];
      blk_r[15] <= bit_len[63:32];
    end
    if (state_r == S_FIN && out_free) begin
      out_data_r.digest_low  <= {chain_r[1], chain_r[0]};
      out_data_r.digest_high <= {chain_r[3], chain_r[2]};
    end
  end

  md5_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mix_start_r),
    .chain    (chain_r),
    .blk_word (blk_r[mix_stat.widx]),
    .stat     (mix_stat),
    .sum      (mix_sum)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/md5_mix.sv */
// ----------------------------------------------------------------------------
// MD5 block mixer
// Runs the 64 rounds of one block through a single round unit, one round per
// cycle, then adds the working words to the chaining words.
// ----------------------------------------------------------------------------
module md5_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  md5_pkg::chain_t    chain,
  input  logic [31:0]        blk_word,
  output md5_pkg::mix_stat_t stat,
  output md5_pkg::chain_t    sum
);
  import md5_pkg::*;

  logic        busy_r;
  logic        fin_r;
  logic [5:0]  rnd_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] t;
  logic [31:0] b_nxt;

  always_comb begin
    t     = a_r + round_f(rnd_r[5:4], b_r, c_r, d_r) + K_TABLE[rnd_r] + blk_word;
    b_nxt = b_r + rotl(t, ROT_TABLE[{rnd_r[5:4], rnd_r[1:0]}]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else if (fin_r) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else if (busy_r) begin
      rnd_r <= rnd_r + 6'd1;
      if (rnd_r == LAST_POS) begin
        fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= chain[0];
      b_r <= chain[1];
      c_r <= chain[2];
      d_r <= chain[3];
    end else if (busy_r && !fin_r) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_nxt;
    end
  end

  assign stat.done = fin_r;
  assign stat.widx = msg_index(rnd_r);
  assign sum[0]    = chain[0] + a_r;
  assign sum[1]    = chain[1] + b_r;
  assign sum[2]    = chain[2] + c_r;
  assign sum[3]    = chain[3] + d_r;

endmodule

/* design/md5_checker.sv */
// ----------------------------------------------------------------------------
// MD5 digest engine checker
// Port-level checks on the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module md5_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input md5_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input md5_pkg::out_item_t out_data
);
  import md5_pkg::*;

  // A reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The end of a message always keeps the engine busy for padding.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("engine ready right after last item");

  // A digest only appears out of a busy period.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while engine was idle");

endmodule

bind md5_digest_engine md5_checker u_md5_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb_md5_digest_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Streams whole messages into the engine one byte per item: a few directed
// messages, then random ones, many sized around the block and padding boundaries.
// A local MD5 predictor computes each digest as the last item is accepted,
// and the monitor compares every returned digest with the oldest prediction.
// Both channels see random idle and stall bursts, with one long stall on the
// result side.
// ----------------------------------------------------------------------------
module tb_md5_digest_engine;

  import md5_pkg::in_item_t;
  import md5_pkg::out_item_t;

  localparam int unsigned ITEM_TARGET = 1500;
  localparam int unsigned MSG_TARGET  = 30;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned DRAIN_WAIT  = 300;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned SHIFT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam int unsigned EDGE_LEN [11] = '{
    55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128
  };

  typedef struct packed {
    in_item_t item;
    logic     wait_drain;
    logic     hold_rx;
  } pend_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  pend_t       pending_q [$];
  out_item_t   digest_q [$];
  logic [31:0] chain_w [4];
  logic [31:0] blk_w [16];
  logic [60:0] msg_bytes;

  bit          in_taken;
  bit          long_hold_req;
  int unsigned idle_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned err_count;
  int unsigned byte_items;
  int unsigned msg_count;

  md5_digest_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void md5_rearm();
    chain_w[0] = 32'h67452301;
    chain_w[1] = 32'hefcdab89;
    chain_w[2] = 32'h98badcfe;
    chain_w[3] = 32'h10325476;
    msg_bytes  = '0;
  endfunction

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int unsigned r, g, s;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      s = SHIFT_BY[(r / 16) * 4 + r % 4];
      t = a + f + SINE_K[r] + blk_w[g];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain_w[0] = chain_w[0] + a;
    chain_w[1] = chain_w[1] + b;
    chain_w[2] = chain_w[2] + c;
    chain_w[3] = chain_w[3] + d;
  endfunction

  function automatic void place_byte(input int unsigned pos, input logic [7:0] v);
    blk_w[pos / 4][8 * (pos % 4) +: 8] = v;
  endfunction

  function automatic void md5_absorb(input in_item_t it);
    int unsigned pos, i;
    logic [63:0] bit_len;
    out_item_t   dig;
    if (it.has_byte) begin
      pos = msg_bytes[5:0];
      place_byte(pos, it.data_byte);
      msg_bytes = msg_bytes + 1'b1;
      if (pos == 63) begin
        md5_compress();
      end
    end
    if (it.last) begin
      pos = msg_bytes[5:0];
      place_byte(pos, 8'h80);
      for (i = pos + 1; i < 64; i++) begin
        place_byte(i, 8'h00);
      end
      if (pos >= 56) begin
        md5_compress();
        for (i = 0; i < 16; i++) begin
          blk_w[i] = '0;
        end
      end
      bit_len    = {msg_bytes, 3'b000};
      blk_w[14]  = bit_len[31:0];
      blk_w[15]  = bit_len[63:32];
      md5_compress();
      dig.digest_low  = {chain_w[1], chain_w[0]};
      dig.digest_high = {chain_w[3], chain_w[2]};
      digest_q.push_back(dig);
      md5_rearm();
    end
  endfunction

  function automatic void push_item(input logic [7:0] data, input logic has, input logic fin,
                                    input logic wait_drain, input logic hold_rx);
    pend_t p;
    p.item.data_byte = data;
    p.item.has_byte  = has;
    p.item.last      = fin;
    p.wait_drain     = wait_drain;
    p.hold_rx        = hold_rx;
    pending_q.push_back(p);
    if (has || fin) begin
      byte_items++;
    end
    if (fin) begin
      msg_count++;
    end
  endfunction

  function automatic void queue_message(input int unsigned len, input bit fold_last,
                                        input bit wait_drain, input bit hold_rx);
    int unsigned i;
    bit first;
    first = 1'b1;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4) begin
        push_item(8'($urandom), 1'b0, 1'b0, first & wait_drain, first & hold_rx);
        first = 1'b0;
      end
      push_item(8'($urandom), 1'b1, fold_last && (i == len - 1),
                first & wait_drain, first & hold_rx);
      first = 1'b0;
    end
    if (!fold_last || len == 0) begin
      push_item(8'($urandom), 1'b0, 1'b1, first & wait_drain, first & hold_rx);
    end
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      md5_absorb(in_data);
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("Unexpected digest %h", out_data);
        err_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_low !== want.digest_low) begin
          $error("digest_low mismatch: expected %h, got %h",
                 want.digest_low, out_data.digest_low);
          err_count++;
        end
        if (out_data.digest_high !== want.digest_high) begin
          $error("digest_high mismatch: expected %h, got %h",
                 want.digest_high, out_data.digest_high);
          err_count++;
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    pend_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (idle_left > 0) begin
      idle_left--;
      in_valid <= 1'b0;
    end else if (pending_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_q[0].wait_drain && digest_q.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      nxt = pending_q.pop_front();
      if (nxt.hold_rx) begin
        long_hold_req = 1'b1;
      end
      in_data  <= nxt.item;
      in_valid <= 1'b1;
      if (pending_q.size() >= QUIET_TAIL && $urandom_range(0, 99) < 15) begin
        idle_left = $urandom_range(1, 8);
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin : receiver
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (pending_q.size() >= QUIET_TAIL && $urandom_range(0, 99) < 8) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int unsigned k, sel, len;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    rst_n     = 1'b0;
    for (k = 0; k < 16; k++) begin
      blk_w[k] = '0;
    end
    md5_rearm();

    // Directed messages: empty, single bytes at both extremes, "abc", ignored items.
    push_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    push_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
    push_item(8'h55, 1'b0, 1'b1, 1'b0, 1'b0);

    // Short messages back to back behind a long result stall.
    for (k = 0; k < 6; k++) begin
      queue_message($urandom_range(0, 4), $urandom_range(0, 1), k == 0, k == 0);
    end

    while (byte_items < ITEM_TARGET || msg_count < MSG_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        len = $urandom_range(0, 15);
      end else if (sel < 8) begin
        len = EDGE_LEN[$urandom_range(0, 10)];
      end else begin
        len = $urandom_range(0, 200);
      end
      queue_message(len, $urandom_range(0, 1), $urandom_range(0, 9) == 0, 1'b0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || digest_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
